// ----- rtl/dtfe_pkg.sv -----
package dtfe_pkg;

    typedef enum logic [2:0] {
        KIND_TAP_RIGHT  = 3'd0,
        KIND_HOLD_RIGHT = 3'd1,
        KIND_TAP_LEFT   = 3'd2,
        KIND_HOLD_LEFT  = 3'd3,
        KIND_BOTH       = 3'd4,
        KIND_LONG_BOTH  = 3'd5,
        KIND_TICK       = 3'd6,
        KIND_ENTER      = 3'd7
    } kind_t;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_COMMIT = 2'd1;
    localparam logic [1:0] ACT_BACK   = 2'd2;
    localparam logic [1:0] ACT_HOME   = 2'd3;

    localparam logic [2:0] FIELD_YEAR   = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;

    localparam logic [1:0] REG_YEAR_MIN     = 2'd0;
    localparam logic [1:0] REG_YEAR_MAX     = 2'd1;
    localparam logic [1:0] REG_REPEAT_START = 2'd2;
    localparam logic [1:0] REG_REPEAT_RATE  = 2'd3;

    localparam int YEAR_W  = 14;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 16;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RST     = 14'd2024;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RST     = 14'd2099;
    localparam logic [MS_W-1:0]   REPEAT_START_RST = 16'd600;
    localparam logic [MS_W-1:0]   REPEAT_RATE_RST  = 16'd150;

    localparam logic [7:0] MONTH_FIRST  = 8'd1;
    localparam logic [7:0] MONTH_LAST   = 8'd12;
    localparam logic [7:0] MONTH_FEB    = 8'd2;
    localparam logic [7:0] DAY_FIRST    = 8'd1;
    localparam logic [7:0] DAY_LONGEST  = 8'd31;
    localparam logic [7:0] HOUR_DEFAULT = 8'd12;

    localparam logic [7:0] MONTH_LEN [12] = '{
        8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
        8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
    };

    // y is a multiple of 25 iff y * inv(25) mod 2^16 <= floor(65535 / 25)
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    localparam logic [10:0] RECIP12 = 11'd171;  // floor(x / 12) = (x * 171) >> 11
    localparam logic [7:0]  RECIP24 = 8'd171;   // floor(x / 24) = (x * 171) >> 12
    localparam logic [8:0]  RECIP60 = 9'd274;   // floor(x / 60) = (x * 274) >> 14

    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        begin
            prod  = 32'(y) * 32'(INV25);
            div25 = (prod[15:0] <= DIV25_LIMIT);
            return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
        end
    endfunction

    function automatic logic [7:0] month_days(input logic [7:0] m, input logic leap);
        logic [7:0] d;
        begin
            if ((m < MONTH_FIRST) || (m > MONTH_LAST))
            begin
                d = DAY_LONGEST;
            end
            else if (m == MONTH_FEB)
            begin
                d = leap ? 8'd29 : 8'd28;
            end
            else
            begin
                d = MONTH_LEN[m[3:0] - 4'd1];
            end
            return d;
        end
    endfunction

    function automatic logic [7:0] next_month(input logic [7:0] m);
        logic [18:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        begin
            prod = 19'(m) * 19'(RECIP12);
            q    = prod[18:11];
            r    = m - ((q << 3) + (q << 2));
            return r + 8'd1;
        end
    endfunction

    function automatic logic [7:0] next_hour(input logic [7:0] h);
        logic [8:0]  x;
        logic [16:0] prod;
        logic [8:0]  q;
        logic [8:0]  r;
        begin
            x    = 9'(h) + 9'd1;
            prod = 17'(x) * 17'(RECIP24);
            q    = 9'(prod[16:12]);
            r    = x - ((q << 4) + (q << 3));
            return r[7:0];
        end
    endfunction

    function automatic logic [7:0] next_minute(input logic [7:0] mi);
        logic [8:0]  x;
        logic [17:0] prod;
        logic [8:0]  q;
        logic [8:0]  r;
        begin
            x    = 9'(mi) + 9'd1;
            prod = 18'(x) * 18'(RECIP60);
            q    = 9'(prod[17:14]);
            r    = x - ((q << 6) - (q << 2));
            return r[7:0];
        end
    endfunction

endpackage

// ----- rtl/dtfe_if.sv -----
interface dtfe_req_if;
    logic                valid;
    logic                ready;
    dtfe_pkg::kind_t     kind;
    logic [31:0]         now_ms;
    logic                btn_right_down;
    logic [31:0]         btn_right_hold_ms;
    logic                load_valid;
    logic [15:0]         load_year;
    logic [7:0]          load_month;
    logic [7:0]          load_day;
    logic [7:0]          load_hour;
    logic [7:0]          load_minute;

    modport source (
        output valid, kind, now_ms, btn_right_down, btn_right_hold_ms,
               load_valid, load_year, load_month, load_day, load_hour, load_minute,
        input  ready
    );
    modport sink (
        input  valid, kind, now_ms, btn_right_down, btn_right_hold_ms,
               load_valid, load_year, load_month, load_day, load_hour, load_minute,
        output ready
    );
endinterface

interface dtfe_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [2:0]  cursor;
    logic [1:0]  action;
    logic        bumped;

    modport source (
        output valid, year, month, day, hour, minute, cursor, action, bumped,
        input  ready
    );
    modport sink (
        input  valid, year, month, day, hour, minute, cursor, action, bumped,
        output ready
    );
endinterface

// ----- rtl/date_time_field_editor.sv -----
// Date and time field editor. Each word on req is one button event, tick or clock
// load; each produces exactly one word on rsp with the edited year, month, day,
// hour, minute, the cursor, the requested action and a bumped flag. A word is
// held in the input register and is applied to the edit state on the edge that
// loads the result register; one word is taken every cycle while rsp keeps up.
// The whole calendar update (wrap, leap-year test, day clamp) is one
// combinational pass between those two registers. Registers are written
// through cfg_we/cfg_index/cfg_data and take effect on the next word;
// writing them leaves the edited values alone.
module date_time_field_editor (
    input  logic                         clk,
    input  logic                         rst_n,
    dtfe_req_if.sink                     req,
    dtfe_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [dtfe_pkg::CFG_W-1:0]   cfg_data
);

    // configuration
    logic [dtfe_pkg::YEAR_W-1:0] year_min_reg;
    logic [dtfe_pkg::YEAR_W-1:0] year_max_reg;
    logic [dtfe_pkg::MS_W-1:0]   repeat_start_reg;
    logic [dtfe_pkg::MS_W-1:0]   repeat_rate_reg;

    // input register
    logic            s1_valid_reg;
    logic            s1_valid_next;
    dtfe_pkg::kind_t in_kind_reg;
    logic [31:0]     in_now_reg;
    logic            in_rdown_reg;
    logic [31:0]     in_rhold_reg;
    logic            in_lvalid_reg;
    logic [15:0]     in_year_reg;
    logic [7:0]      in_month_reg;
    logic [7:0]      in_day_reg;
    logic [7:0]      in_hour_reg;
    logic [7:0]      in_minute_reg;

    // edit state, which is also the shown result
    logic [15:0] edit_year_reg,   edit_year_next;
    logic [7:0]  edit_month_reg,  edit_month_next;
    logic [7:0]  edit_day_reg,    edit_day_next;
    logic [7:0]  edit_hour_reg,   edit_hour_next;
    logic [7:0]  edit_minute_reg, edit_minute_next;
    logic [2:0]  cursor_reg,      cursor_next;
    logic [31:0] last_repeat_reg, last_repeat_next;

    // result register
    logic       rsp_valid_reg, rsp_valid_next;
    logic [1:0] action_reg,    action_next;
    logic       bumped_reg,    bumped_next;

    logic        in_take;
    logic        advance;
    logic [15:0] ymin16;
    logic [15:0] ymax16;
    logic [15:0] year_inc;
    logic        load_ok;
    logic        tick_fire;
    logic        do_inc;
    logic [15:0] cand_year;
    logic [7:0]  cand_month;
    logic [7:0]  cand_day;
    logic [7:0]  dim;
    logic [7:0]  fit_day;
    logic [7:0]  day_inc;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.year   = edit_year_reg;
    assign rsp.month  = edit_month_reg;
    assign rsp.day    = edit_day_reg;
    assign rsp.hour   = edit_hour_reg;
    assign rsp.minute = edit_minute_reg;
    assign rsp.cursor = cursor_reg;
    assign rsp.action = action_reg;
    assign rsp.bumped = bumped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg     <= dtfe_pkg::YEAR_MIN_RST;
            year_max_reg     <= dtfe_pkg::YEAR_MAX_RST;
            repeat_start_reg <= dtfe_pkg::REPEAT_START_RST;
            repeat_rate_reg  <= dtfe_pkg::REPEAT_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtfe_pkg::REG_YEAR_MIN:     year_min_reg     <= cfg_data[dtfe_pkg::YEAR_W-1:0];
                dtfe_pkg::REG_YEAR_MAX:     year_max_reg     <= cfg_data[dtfe_pkg::YEAR_W-1:0];
                dtfe_pkg::REG_REPEAT_START: repeat_start_reg <= cfg_data[dtfe_pkg::MS_W-1:0];
                dtfe_pkg::REG_REPEAT_RATE:  repeat_rate_reg  <= cfg_data[dtfe_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg   <= req.kind;
            in_now_reg    <= req.now_ms;
            in_rdown_reg  <= req.btn_right_down;
            in_rhold_reg  <= req.btn_right_hold_ms;
            in_lvalid_reg <= req.load_valid;
            in_year_reg   <= req.load_year;
            in_month_reg  <= req.load_month;
            in_day_reg    <= req.load_day;
            in_hour_reg   <= req.load_hour;
            in_minute_reg <= req.load_minute;
        end
    end

    always_comb
    begin
        ymin16   = 16'(year_min_reg);
        ymax16   = 16'(year_max_reg);
        year_inc = (edit_year_reg >= ymax16) ? ymin16 : edit_year_reg + 16'd1;
        load_ok  = in_lvalid_reg && (in_year_reg >= ymin16) && (in_year_reg <= ymax16);
        // zero in last_repeat means no repeat has happened yet
        tick_fire = in_rdown_reg && (in_rhold_reg >= 32'(repeat_start_reg)) &&
                    ((last_repeat_reg == 32'd0) ||
                     ((in_now_reg - last_repeat_reg) >= 32'(repeat_rate_reg)));
        do_inc = (in_kind_reg == dtfe_pkg::KIND_TAP_RIGHT) ||
                 (in_kind_reg == dtfe_pkg::KIND_HOLD_RIGHT) ||
                 ((in_kind_reg == dtfe_pkg::KIND_TICK) && tick_fire);

        // date that the day has to fit into after this word
        cand_year  = edit_year_reg;
        cand_month = edit_month_reg;
        cand_day   = edit_day_reg;
        if (in_kind_reg == dtfe_pkg::KIND_ENTER)
        begin
            cand_year  = load_ok ? in_year_reg  : ymin16;
            cand_month = load_ok ? in_month_reg : dtfe_pkg::MONTH_FIRST;
            cand_day   = load_ok ? in_day_reg   : dtfe_pkg::DAY_FIRST;
        end
        else if (do_inc && (cursor_reg == dtfe_pkg::FIELD_YEAR))
        begin
            cand_year = year_inc;
        end
        else if (do_inc && (cursor_reg == dtfe_pkg::FIELD_MONTH))
        begin
            cand_month = dtfe_pkg::next_month(edit_month_reg);
        end

        dim = dtfe_pkg::month_days(cand_month, dtfe_pkg::is_leap(cand_year));
        if (cand_day > dim)
        begin
            fit_day = dim;
        end
        else if (cand_day == 8'd0)
        begin
            fit_day = dtfe_pkg::DAY_FIRST;
        end
        else
        begin
            fit_day = cand_day;
        end
        day_inc = (edit_day_reg >= dim) ? dtfe_pkg::DAY_FIRST : edit_day_reg + 8'd1;
    end

    always_comb
    begin
        edit_year_next   = edit_year_reg;
        edit_month_next  = edit_month_reg;
        edit_day_next    = edit_day_reg;
        edit_hour_next   = edit_hour_reg;
        edit_minute_next = edit_minute_reg;
        cursor_next      = cursor_reg;
        last_repeat_next = last_repeat_reg;
        action_next      = action_reg;
        bumped_next      = bumped_reg;
        rsp_valid_next   = rsp_valid_reg;
        s1_valid_next    = s1_valid_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (advance)
        begin
            s1_valid_next  = 1'b0;
            rsp_valid_next = 1'b1;
            action_next    = dtfe_pkg::ACT_NONE;
            bumped_next    = do_inc;

            if (do_inc)
            begin
                case (cursor_reg)
                    dtfe_pkg::FIELD_YEAR:
                    begin
                        edit_year_next = cand_year;
                        edit_day_next  = fit_day;
                    end
                    dtfe_pkg::FIELD_MONTH:
                    begin
                        edit_month_next = cand_month;
                        edit_day_next   = fit_day;
                    end
                    dtfe_pkg::FIELD_DAY:    edit_day_next    = day_inc;
                    dtfe_pkg::FIELD_HOUR:   edit_hour_next   = dtfe_pkg::next_hour(edit_hour_reg);
                    dtfe_pkg::FIELD_MINUTE: edit_minute_next = dtfe_pkg::next_minute(edit_minute_reg);
                    default:
                    begin
                    end
                endcase
            end

            case (in_kind_reg)
                dtfe_pkg::KIND_HOLD_RIGHT: last_repeat_next = in_now_reg;
                dtfe_pkg::KIND_TAP_LEFT:
                begin
                    cursor_next = (cursor_reg >= dtfe_pkg::FIELD_MINUTE) ?
                                  dtfe_pkg::FIELD_YEAR : cursor_reg + 3'd1;
                end
                dtfe_pkg::KIND_HOLD_LEFT: action_next = dtfe_pkg::ACT_COMMIT;
                dtfe_pkg::KIND_BOTH:      action_next = dtfe_pkg::ACT_BACK;
                dtfe_pkg::KIND_LONG_BOTH: action_next = dtfe_pkg::ACT_HOME;
                dtfe_pkg::KIND_TICK:
                begin
                    if (!in_rdown_reg)
                    begin
                        last_repeat_next = 32'd0;
                    end
                    else if (tick_fire)
                    begin
                        last_repeat_next = in_now_reg;
                    end
                end
                dtfe_pkg::KIND_ENTER:
                begin
                    edit_year_next   = cand_year;
                    edit_month_next  = cand_month;
                    edit_day_next    = fit_day;
                    edit_hour_next   = load_ok ? in_hour_reg : dtfe_pkg::HOUR_DEFAULT;
                    edit_minute_next = load_ok ? in_minute_reg : 8'd0;
                    cursor_next      = dtfe_pkg::FIELD_YEAR;
                    last_repeat_next = 32'd0;
                end
                default:
                begin
                end
            endcase
        end
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            edit_year_reg   <= 16'(dtfe_pkg::YEAR_MIN_RST);
            edit_month_reg  <= dtfe_pkg::MONTH_FIRST;
            edit_day_reg    <= dtfe_pkg::DAY_FIRST;
            edit_hour_reg   <= dtfe_pkg::HOUR_DEFAULT;
            edit_minute_reg <= 8'd0;
            cursor_reg      <= dtfe_pkg::FIELD_YEAR;
            last_repeat_reg <= 32'd0;
            action_reg      <= dtfe_pkg::ACT_NONE;
            bumped_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            edit_year_reg   <= edit_year_next;
            edit_month_reg  <= edit_month_next;
            edit_day_reg    <= edit_day_next;
            edit_hour_reg   <= edit_hour_next;
            edit_minute_reg <= edit_minute_next;
            cursor_reg      <= cursor_next;
            last_repeat_reg <= last_repeat_next;
            action_reg      <= action_next;
            bumped_reg      <= bumped_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= dtfe_pkg::FIELD_MINUTE)
        else $error("cursor beyond last field");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (edit_day_reg != 8'd0) && (edit_day_reg <= dtfe_pkg::DAY_LONGEST))
        else $error("day outside 1..31");

    a_bump_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && bumped_reg) |-> (action_reg == dtfe_pkg::ACT_NONE))
        else $error("bumped word carries an action");

    a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("stalled input word lost");
`endif

endmodule

// ----- tb/sv/date_time_field_editor_tb.sv -----
`timescale 1ns / 100ps

module date_time_field_editor_tb;
    import dtfe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 175;

    localparam logic [7:0] DAYS_PER_MONTH [12] = '{
        8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
        8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
    };

    typedef struct packed {
        kind_t       kind;
        logic [31:0] now_ms;
        logic        right_down;
        logic [31:0] right_hold_ms;
        logic        load_valid;
        logic [15:0] load_year;
        logic [7:0]  load_month;
        logic [7:0]  load_day;
        logic [7:0]  load_hour;
        logic [7:0]  load_minute;
    } req_word_t;

    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [2:0]  cursor;
        logic [1:0]  action;
        logic        bumped;
    } rsp_word_t;

    // pinned rows carry a hand-written expectation instead of the predicted one
    typedef struct packed {
        req_word_t w;
        logic      pinned;
        rsp_word_t value;
    } word_row_t;

    logic clk;
    logic rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    dtfe_req_if req();
    dtfe_rsp_if rsp();

    date_time_field_editor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // calendar predictor state
    logic [13:0] cfg_year_min;
    logic [13:0] cfg_year_max;
    logic [15:0] cfg_repeat_start;
    logic [15:0] cfg_repeat_rate;
    logic [15:0] cal_year;
    logic [7:0]  cal_month;
    logic [7:0]  cal_day;
    logic [7:0]  cal_hour;
    logic [7:0]  cal_minute;
    logic [2:0]  cal_cursor;
    logic [31:0] repeat_mark;

    word_row_t sent_q [$];
    rsp_word_t shown_q [$];

    logic        idle_on;
    logic [31:0] clock_ms;
    int          mismatches;
    int          words_checked;
    int          bumps_seen;
    int          settings_used;
    int          cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d words outstanding", $time, shown_q.size());
            $display("date_time_field_editor_tb: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp.ready = !idle_on || ($urandom_range(99) >= 21);
    end

    function automatic logic [7:0] month_length(input logic [15:0] y, input logic [7:0] m);
        logic leap;
        leap = (y % 16'd4 == 0 && y % 16'd100 != 0) || (y % 16'd400 == 0);
        if (m == 8'd0 || m > 8'd12)
            return 8'd31;
        if (m == 8'd2)
            return leap ? 8'd29 : 8'd28;
        return DAYS_PER_MONTH[4'(m - 8'd1)];
    endfunction

    function automatic void fit_cal_day();
        logic [7:0] lim;
        lim = month_length(cal_year, cal_month);
        if (cal_day > lim)
            cal_day = lim;
        if (cal_day == 8'd0)
            cal_day = 8'd1;
    endfunction

    function automatic void bump_field();
        case (cal_cursor)
            FIELD_YEAR:
            begin
                cal_year = (cal_year >= 16'(cfg_year_max)) ? 16'(cfg_year_min)
                                                           : cal_year + 16'd1;
                fit_cal_day();
            end
            FIELD_MONTH:
            begin
                cal_month = (cal_month % 8'd12) + 8'd1;
                fit_cal_day();
            end
            FIELD_DAY:
                cal_day = (cal_day >= month_length(cal_year, cal_month)) ? 8'd1
                                                                         : cal_day + 8'd1;
            FIELD_HOUR:
                cal_hour = 8'((9'(cal_hour) + 9'd1) % 9'd24);
            FIELD_MINUTE:
                cal_minute = 8'((9'(cal_minute) + 9'd1) % 9'd60);
            default:
                ;
        endcase
    endfunction

    function automatic rsp_word_t apply_event(input req_word_t w);
        rsp_word_t  r;
        logic [1:0] act;
        logic       bump;
        act  = ACT_NONE;
        bump = 1'b0;
        case (w.kind)
            KIND_TAP_RIGHT:
            begin
                bump_field();
                bump = 1'b1;
            end
            KIND_HOLD_RIGHT:
            begin
                repeat_mark = w.now_ms;
                bump_field();
                bump = 1'b1;
            end
            KIND_TAP_LEFT:
                cal_cursor = (cal_cursor == FIELD_MINUTE) ? FIELD_YEAR : cal_cursor + 3'd1;
            KIND_HOLD_LEFT:
                act = ACT_COMMIT;
            KIND_BOTH:
                act = ACT_BACK;
            KIND_LONG_BOTH:
                act = ACT_HOME;
            KIND_TICK:
            begin
                if (!w.right_down)
                begin
                    repeat_mark = 32'd0;
                end
                else if (w.right_hold_ms >= 32'(cfg_repeat_start) &&
                         (repeat_mark == 32'd0 ||
                          w.now_ms - repeat_mark >= 32'(cfg_repeat_rate)))
                begin
                    repeat_mark = w.now_ms;
                    bump_field();
                    bump = 1'b1;
                end
            end
            default:
            begin
                if (w.load_valid && w.load_year >= 16'(cfg_year_min) &&
                    w.load_year <= 16'(cfg_year_max))
                begin
                    cal_year   = w.load_year;
                    cal_month  = w.load_month;
                    cal_day    = w.load_day;
                    cal_hour   = w.load_hour;
                    cal_minute = w.load_minute;
                end
                else
                begin
                    cal_year   = 16'(cfg_year_min);
                    cal_month  = 8'd1;
                    cal_day    = 8'd1;
                    cal_hour   = 8'd12;
                    cal_minute = 8'd0;
                end
                fit_cal_day();
                cal_cursor  = FIELD_YEAR;
                repeat_mark = 32'd0;
            end
        endcase
        r.year   = cal_year;
        r.month  = cal_month;
        r.day    = cal_day;
        r.hour   = cal_hour;
        r.minute = cal_minute;
        r.cursor = cal_cursor;
        r.action = act;
        r.bumped = bump;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        word_row_t row;
        rsp_word_t want;
        rsp_word_t got;
        rsp_word_t predicted;
        if (rst_n)
        begin
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    REG_YEAR_MIN:     cfg_year_min     = cfg_data[13:0];
                    REG_YEAR_MAX:     cfg_year_max     = cfg_data[13:0];
                    REG_REPEAT_START: cfg_repeat_start = cfg_data;
                    REG_REPEAT_RATE:  cfg_repeat_rate  = cfg_data;
                    default:          ;
                endcase
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                row = sent_q.pop_front();
                predicted = apply_event(row.w);
                shown_q.push_back(row.pinned ? row.value : predicted);
            end
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                got.year   = rsp.year;
                got.month  = rsp.month;
                got.day    = rsp.day;
                got.hour   = rsp.hour;
                got.minute = rsp.minute;
                got.cursor = rsp.cursor;
                got.action = rsp.action;
                got.bumped = rsp.bumped;
                if (shown_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none got %h", $time, got);
                end
                else
                begin
                    want = shown_q.pop_front();
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("day", want.day, got.day);
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("cursor", want.cursor, got.cursor);
                    check_field("action", want.action, got.action);
                    check_field("bumped", want.bumped, got.bumped);
                    words_checked++;
                    if (want.bumped)
                        bumps_seen++;
                end
            end
        end
    end

    function automatic req_word_t mk_ev(input kind_t k, input logic [31:0] now,
                                        input logic rd, input logic [31:0] hold);
        req_word_t w;
        w = '0;
        w.kind          = k;
        w.now_ms        = now;
        w.right_down    = rd;
        w.right_hold_ms = hold;
        return w;
    endfunction

    function automatic req_word_t mk_load(input logic lv, input logic [15:0] y,
                                          input logic [7:0] m, input logic [7:0] d,
                                          input logic [7:0] h, input logic [7:0] mi);
        req_word_t w;
        w = '0;
        w.kind        = KIND_ENTER;
        w.load_valid  = lv;
        w.load_year   = y;
        w.load_month  = m;
        w.load_day    = d;
        w.load_hour   = h;
        w.load_minute = mi;
        return w;
    endfunction

    function automatic rsp_word_t shown(input logic [15:0] y, input logic [7:0] m,
                                        input logic [7:0] d, input logic [7:0] h,
                                        input logic [7:0] mi, input logic [2:0] cur,
                                        input logic [1:0] act, input logic bump);
        rsp_word_t r;
        r.year   = y;
        r.month  = m;
        r.day    = d;
        r.hour   = h;
        r.minute = mi;
        r.cursor = cur;
        r.action = act;
        r.bumped = bump;
        return r;
    endfunction

    function automatic word_row_t pin_row(input req_word_t w, input rsp_word_t r);
        word_row_t row;
        row.w      = w;
        row.pinned = 1'b1;
        row.value  = r;
        return row;
    endfunction

    function automatic word_row_t open_row(input req_word_t w);
        word_row_t row;
        row.w      = w;
        row.pinned = 1'b0;
        row.value  = '0;
        return row;
    endfunction

    function automatic req_word_t random_word();
        req_word_t   w;
        int unsigned pick;
        int unsigned day_pick;
        w = '0;
        clock_ms = clock_ms + $urandom_range(400);
        w.now_ms        = ($urandom_range(9) == 0) ? $urandom : clock_ms;
        w.right_down    = ($urandom_range(4) != 0);
        w.right_hold_ms = ($urandom_range(9) == 0) ? $urandom
                                                   : $urandom_range(2 * cfg_repeat_start + 50);
        pick = $urandom_range(99);
        if (pick < 25)
            w.kind = KIND_TAP_RIGHT;
        else if (pick < 33)
            w.kind = KIND_HOLD_RIGHT;
        else if (pick < 48)
            w.kind = KIND_TAP_LEFT;
        else if (pick < 73)
            w.kind = KIND_TICK;
        else if (pick < 76)
            w.kind = KIND_HOLD_LEFT;
        else if (pick < 79)
            w.kind = KIND_BOTH;
        else if (pick < 82)
            w.kind = KIND_LONG_BOTH;
        else
            w.kind = KIND_ENTER;
        if (w.kind == KIND_ENTER)
        begin
            if ($urandom_range(9) < 7 && cfg_year_min <= cfg_year_max)
            begin
                // plausible clock value inside the year window
                w.load_valid = 1'b1;
                case ($urandom_range(3))
                    0:       w.load_year = 16'(cfg_year_min);
                    1:       w.load_year = 16'(cfg_year_max);
                    default: w.load_year = 16'($urandom_range(cfg_year_max, cfg_year_min));
                endcase
                w.load_month = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(12, 1));
                day_pick = $urandom_range(9);
                if (day_pick == 0)
                    w.load_day = 8'($urandom_range(255));
                else if (day_pick < 5)
                    w.load_day = 8'($urandom_range(31, 1));
                else
                    w.load_day = 8'($urandom_range(31, 27));
                w.load_hour   = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(23));
                w.load_minute = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(59));
            end
            else
            begin
                w.load_valid  = 1'($urandom_range(1));
                w.load_year   = 16'($urandom);
                w.load_month  = 8'($urandom);
                w.load_day    = 8'($urandom);
                w.load_hour   = 8'($urandom);
                w.load_minute = 8'($urandom);
            end
        end
        return w;
    endfunction

    task automatic send_word(input word_row_t row);
        while (idle_on && $urandom_range(99) < 21)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        sent_q.push_back(row);
        req.valid             = 1'b1;
        req.kind              = row.w.kind;
        req.now_ms            = row.w.now_ms;
        req.btn_right_down    = row.w.right_down;
        req.btn_right_hold_ms = row.w.right_hold_ms;
        req.load_valid        = row.w.load_valid;
        req.load_year         = row.w.load_year;
        req.load_month        = row.w.load_month;
        req.load_day          = row.w.load_day;
        req.load_hour         = row.w.load_hour;
        req.load_minute       = row.w.load_minute;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid and hold until every expected word is back
    task automatic wait_drained();
        req.valid = 1'b0;
        while (sent_q.size() != 0 || shown_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_registers(input logic [CFG_W-1:0] ymin, input logic [CFG_W-1:0] ymax,
                                 input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] rate);
        write_reg(REG_YEAR_MIN, ymin);
        write_reg(REG_YEAR_MAX, ymax);
        write_reg(REG_REPEAT_START, start);
        write_reg(REG_REPEAT_RATE, rate);
        settings_used++;
    endtask

    initial
    begin
        word_row_t rows [$];
        int        ph;
        int        n;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_YEAR_MIN;
        cfg_data              = '0;
        req.valid             = 1'b0;
        req.kind              = KIND_TAP_RIGHT;
        req.now_ms            = '0;
        req.btn_right_down    = 1'b0;
        req.btn_right_hold_ms = '0;
        req.load_valid        = 1'b0;
        req.load_year         = '0;
        req.load_month        = '0;
        req.load_day          = '0;
        req.load_hour         = '0;
        req.load_minute       = '0;
        rsp.ready             = 1'b0;
        idle_on               = 1'b1;
        clock_ms              = $urandom;
        mismatches            = 0;
        words_checked         = 0;
        bumps_seen            = 0;
        settings_used         = 1;
        cycles                = 0;

        cfg_year_min     = YEAR_MIN_RST;
        cfg_year_max     = YEAR_MAX_RST;
        cfg_repeat_start = REPEAT_START_RST;
        cfg_repeat_rate  = REPEAT_RATE_RST;
        cal_year         = 16'(YEAR_MIN_RST);
        cal_month        = 8'd1;
        cal_day          = 8'd1;
        cal_hour         = 8'd12;
        cal_minute       = 8'd0;
        cal_cursor       = FIELD_YEAR;
        repeat_mark      = 32'd0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        rows.push_back(pin_row(mk_ev(KIND_BOTH, 0, 0, 0),
                               shown(2024, 1, 1, 12, 0, FIELD_YEAR, ACT_BACK, 0)));
        rows.push_back(pin_row(mk_ev(KIND_LONG_BOTH, 0, 0, 0),
                               shown(2024, 1, 1, 12, 0, FIELD_YEAR, ACT_HOME, 0)));
        rows.push_back(pin_row(mk_ev(KIND_HOLD_LEFT, 0, 0, 0),
                               shown(2024, 1, 1, 12, 0, FIELD_YEAR, ACT_COMMIT, 0)));
        rows.push_back(pin_row(mk_ev(KIND_TAP_RIGHT, 0, 0, 0),
                               shown(2025, 1, 1, 12, 0, FIELD_YEAR, ACT_NONE, 1)));
        rows.push_back(pin_row(mk_load(1, 2099, 12, 31, 23, 59),
                               shown(2099, 12, 31, 23, 59, FIELD_YEAR, ACT_NONE, 0)));
        // year at the top of the window wraps to the bottom
        rows.push_back(pin_row(mk_ev(KIND_TAP_RIGHT, 0, 0, 0),
                               shown(2024, 12, 31, 23, 59, FIELD_YEAR, ACT_NONE, 1)));
        rows.push_back(pin_row(mk_load(0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                               shown(2024, 1, 1, 12, 0, FIELD_YEAR, ACT_NONE, 0)));
        rows.push_back(pin_row(mk_load(1, 16'hFFFF, 0, 0, 0, 0),
                               shown(2024, 1, 1, 12, 0, FIELD_YEAR, ACT_NONE, 0)));
        // leap February clamps to 29, then 28 once the year moves on
        rows.push_back(pin_row(mk_load(1, 2024, 2, 31, 23, 59),
                               shown(2024, 2, 29, 23, 59, FIELD_YEAR, ACT_NONE, 0)));
        rows.push_back(pin_row(mk_ev(KIND_TAP_RIGHT, 0, 0, 0),
                               shown(2025, 2, 28, 23, 59, FIELD_YEAR, ACT_NONE, 1)));
        // out-of-range month, zero day, oversized hour and minute
        rows.push_back(pin_row(mk_load(1, 2050, 255, 0, 255, 255),
                               shown(2050, 255, 1, 255, 255, FIELD_YEAR, ACT_NONE, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_LEFT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_RIGHT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_LEFT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_HOLD_RIGHT, 1000, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TICK, 1149, 1, 600)));
        rows.push_back(open_row(mk_ev(KIND_TICK, 1150, 1, 600)));
        rows.push_back(open_row(mk_ev(KIND_TICK, 1200, 0, 600)));
        rows.push_back(open_row(mk_ev(KIND_TICK, 5000, 1, 599)));
        rows.push_back(open_row(mk_ev(KIND_TICK, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF)));
        // repeat at time zero reads as no repeat yet
        rows.push_back(open_row(mk_ev(KIND_HOLD_RIGHT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TICK, 3, 1, 600)));
        rows.push_back(open_row(mk_ev(KIND_TAP_LEFT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_RIGHT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_LEFT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_RIGHT, 0, 0, 0)));
        rows.push_back(open_row(mk_ev(KIND_TAP_LEFT, 0, 0, 0)));

        foreach (rows[i])
            send_word(rows[i]);
        wait_drained();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                // year registers take only 14 bits: 16'hC000 reads back as 0
                1: set_registers(16'hC000, 16'hFFFF, 16'h0000, 16'h0000);
                2: set_registers(16'd9999, 16'd9999, 16'hFFFF, 16'hFFFF);
                3: set_registers(16'd2100, 16'd1900, 16'($urandom_range(40)),
                                 16'($urandom_range(40)));
                4: set_registers(16'd1896, 16'd2104, 16'($urandom_range(1000)),
                                 16'($urandom_range(300)));
                5: set_registers(16'($urandom_range(9999)), 16'($urandom_range(9999)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535)));
                default: ;
            endcase
            idle_on = (ph != 4);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == 90)
                    wait_drained();
                send_word(open_row(random_word()));
            end
            wait_drained();
        end

        idle_on = 1'b1;
        repeat (4) @(negedge clk);
        $display("checked %0d result words (%0d field increments) over %0d register settings",
                 words_checked, bumps_seen, settings_used);
        if (mismatches == 0 && shown_q.size() == 0)
            $display("date_time_field_editor_tb: PASS");
        else
            $display("date_time_field_editor_tb: FAIL");
        $finish;
    end

endmodule

// ----- date_time_field_editor.f -----
rtl/dtfe_pkg.sv
rtl/dtfe_if.sv
rtl/date_time_field_editor.sv
tb/sv/date_time_field_editor_tb.sv
